@@ rtl/leb_pkg.sv @@
// shared constants and types for the line edit buffer
package leb_pkg;

	localparam int LINE_CHARS_DEF = 256;

	localparam int LEN_W  = 9;
	localparam int CHAR_W = 7;
	localparam int CODE_W = 8;

	localparam logic [CODE_W-1:0] KEY_BACKSPACE = 8'h08;
	localparam logic [CODE_W-1:0] KEY_DELETE    = 8'h2E;
	localparam logic [CODE_W-1:0] KEY_LEFT      = 8'h25;
	localparam logic [CODE_W-1:0] KEY_RIGHT     = 8'h27;
	localparam logic [CODE_W-1:0] KEY_INSERT    = 8'h2D;
	localparam logic [CODE_W-1:0] PRINT_LOW     = 8'd32;
	localparam logic [CODE_W-1:0] PRINT_HIGH    = 8'd126;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_CHAR = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0]  text_length;
		logic [LEN_W-1:0]  caret_position;
		logic              insert_on;
		logic [CHAR_W-1:0] char_under_caret;
		logic              dropped_full;
	} leb_result_t;

endpackage

@@ rtl/leb_store.sv @@
// character memory of the line, one write and one registered read port
module leb_store #(
	parameter int LINE_CHARS = leb_pkg::LINE_CHARS_DEF,
	localparam int AW = $clog2(LINE_CHARS)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [leb_pkg::CHAR_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [leb_pkg::CHAR_W-1:0] rd_data
);

	logic [leb_pkg::CHAR_W-1:0] text_mem_q [LINE_CHARS];
	logic [leb_pkg::CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= text_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/leb_seq.sv @@
// edit sequencer: decodes an item, walks the shift index unit, looks up the caret char
module leb_seq #(
	parameter int LINE_CHARS = leb_pkg::LINE_CHARS_DEF,
	localparam int AW = $clog2(LINE_CHARS),
	localparam int CW = $clog2(LINE_CHARS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       cmd,
	input  logic [leb_pkg::CODE_W-1:0] key_code,
	input  logic                       key_released,
	output logic                       idle,
	output logic                       res_valid,
	input  logic                       res_take,
	output leb_pkg::leb_result_t       res,
	output logic                       mem_wr_en,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [leb_pkg::CHAR_W-1:0] mem_wr_data,
	output logic                       mem_rd_en,
	output logic [AW-1:0]              mem_rd_addr,
	input  logic [leb_pkg::CHAR_W-1:0] mem_rd_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_PUT   = 3'd3;
	localparam logic [2:0] ST_LOOK  = 3'd4;
	localparam logic [2:0] ST_LOOKW = 3'd5;

	logic [2:0]  state_q;
	logic [CW-1:0] len_q, caret_q;
	logic        ins_q, dropped_q, put_q, dir_right_q, look_hit_q;
	logic [leb_pkg::CHAR_W-1:0] ch_q;
	logic [AW-1:0] put_addr_q, rd_idx_q, stop_q;
	logic        wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;

	// decode of the incoming item
	logic [CW-1:0] caret_inc, caret_dec, len_inc, len_dec;
	logic          caret_at_end, is_full, printable;
	logic [CW-1:0] nxt_len, nxt_caret;
	logic          nxt_ins, nxt_drop, nxt_shift, nxt_right, nxt_put;
	logic [CW-1:0] nxt_start, nxt_stop, nxt_put_addr;

	// shared index step unit
	logic [AW-1:0] idx_step, idx_next, idx_back;

	assign caret_inc    = caret_q + CW'(1);
	assign caret_dec    = caret_q - CW'(1);
	assign len_inc      = len_q + CW'(1);
	assign len_dec      = len_q - CW'(1);
	assign caret_at_end = (caret_q == len_q);
	assign is_full      = (len_q == CW'(LINE_CHARS));
	assign printable    = (key_code >= leb_pkg::PRINT_LOW) && (key_code <= leb_pkg::PRINT_HIGH);

	always_comb begin
		nxt_len      = len_q;
		nxt_caret    = caret_q;
		nxt_ins      = ins_q;
		nxt_drop     = 1'b0;
		nxt_shift    = 1'b0;
		nxt_right    = 1'b0;
		nxt_put      = 1'b0;
		nxt_start    = caret_q;
		nxt_stop     = len_dec;
		nxt_put_addr = caret_q;
		if (cmd == leb_pkg::CMD_KEY) begin
			if (!key_released) begin
				case (key_code)
					leb_pkg::KEY_BACKSPACE: begin
						if (caret_q != '0) begin
							nxt_len   = len_dec;
							nxt_caret = caret_dec;
							nxt_shift = !caret_at_end;
							nxt_start = caret_q;
						end
					end
					leb_pkg::KEY_DELETE: begin
						if (!caret_at_end) begin
							nxt_len   = len_dec;
							nxt_shift = (caret_inc != len_q);
							nxt_start = caret_inc;
						end
					end
					leb_pkg::KEY_LEFT: begin
						if (caret_q != '0) begin
							nxt_caret = caret_dec;
						end
					end
					leb_pkg::KEY_RIGHT: begin
						if (!caret_at_end) begin
							nxt_caret = caret_inc;
						end
					end
					leb_pkg::KEY_INSERT: begin
						nxt_ins = !ins_q;
					end
					default: begin
					end
				endcase
			end
		end else if (printable) begin
			if (ins_q) begin
				if (is_full) begin
					nxt_drop = 1'b1;
				end else begin
					nxt_len   = len_inc;
					nxt_caret = caret_inc;
					nxt_put   = 1'b1;
					nxt_shift = !caret_at_end;
					nxt_right = 1'b1;
					nxt_start = len_dec;
					nxt_stop  = caret_q;
				end
			end else if (!caret_at_end || !is_full) begin
				nxt_put   = 1'b1;
				nxt_caret = caret_inc;
				if (caret_at_end) begin
					nxt_len = len_inc;
				end
			end else begin
				nxt_drop = 1'b1;
			end
		end
	end

	// +1 when walking up (removal), -1 when walking down (insertion)
	assign idx_step = dir_right_q ? '1 : AW'(1);
	assign idx_next = rd_idx_q + idx_step;
	assign idx_back = rd_idx_q - idx_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			caret_q    <= '0;
			ins_q      <= 1'b1;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						len_q   <= nxt_len;
						caret_q <= nxt_caret;
						ins_q   <= nxt_ins;
						if (nxt_shift) begin
							state_q <= ST_SHIFT;
						end else if (nxt_put) begin
							state_q <= ST_PUT;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_SHIFT: begin
					wr_pend_s1 <= 1'b1;
					if (rd_idx_q == stop_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= put_q ? ST_PUT : ST_LOOK;
				end
				ST_PUT: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_LOOKW;
				end
				ST_LOOKW: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dropped_q   <= nxt_drop;
			put_q       <= nxt_put;
			dir_right_q <= nxt_right;
			ch_q        <= key_code[leb_pkg::CHAR_W-1:0];
			put_addr_q  <= nxt_put_addr[AW-1:0];
			rd_idx_q    <= nxt_start[AW-1:0];
			stop_q      <= nxt_stop[AW-1:0];
		end
		if (state_q == ST_SHIFT) begin
			rd_idx_q   <= idx_next;
			wr_addr_s1 <= idx_back;
		end
		if (state_q == ST_LOOK) begin
			look_hit_q <= (caret_q != len_q);
		end
	end

	// memory port steering
	assign mem_wr_en   = wr_pend_s1 || (state_q == ST_PUT);
	assign mem_wr_addr = wr_pend_s1 ? wr_addr_s1 : put_addr_q;
	assign mem_wr_data = wr_pend_s1 ? mem_rd_data : ch_q;
	assign mem_rd_en   = (state_q == ST_SHIFT) || (state_q == ST_LOOK && caret_q != len_q);
	assign mem_rd_addr = (state_q == ST_SHIFT) ? rd_idx_q : caret_q[AW-1:0];

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_LOOKW);

	always_comb begin
		res.text_length      = leb_pkg::LEN_W'(len_q);
		res.caret_position   = leb_pkg::LEN_W'(caret_q);
		res.insert_on        = ins_q;
		res.char_under_caret = look_hit_q ? mem_rd_data : '0;
		res.dropped_full     = dropped_q;
	end

endmodule

@@ rtl/line_edit_buffer.sv @@
// top level of the line edit buffer: handshakes, result register, sequencer and memory
//
//  channel | direction | handshake           | item fields
//  --------+-----------+---------------------+-----------------------------------------------
//  input   | in        | in_valid / in_stall | cmd, key_code, key_released
//  output  | out       | out_valid/out_stall | text_length, caret_position, insert_on,
//          |           |                     | char_under_caret, dropped_full
//
// an item is accepted in the idle state; for an insertion or removal inside the text the
// sequencer then shifts the characters after the edit point and drains, writes when a
// character is written, looks up the caret character and waits for the result register
// the single memory port pair sets the shift rate: one character moves per cycle
// arst_n clears length, caret and sequencer and sets insert mode; the memory is not cleared
// a stalled output holds its result; the next item is accepted meanwhile and its result
// waits in the sequencer, stalling the input, until the result register frees up
module line_edit_buffer #(
	parameter int LINE_CHARS = leb_pkg::LINE_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input item channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [leb_pkg::CODE_W-1:0]  key_code,
	input  logic                        key_released,
	// result item channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [leb_pkg::LEN_W-1:0]   text_length,
	output logic [leb_pkg::LEN_W-1:0]   caret_position,
	output logic                        insert_on,
	output logic [leb_pkg::CHAR_W-1:0]  char_under_caret,
	output logic                        dropped_full
);

	localparam int AW = $clog2(LINE_CHARS);

	logic                        seq_idle;
	logic                        res_valid;
	logic                        res_take;
	logic                        in_accept;
	leb_pkg::leb_result_t        res;
	leb_pkg::leb_result_t        out_q;
	logic                        out_valid_q;

	logic                        mem_wr_en, mem_rd_en;
	logic [AW-1:0]               mem_wr_addr, mem_rd_addr;
	logic [leb_pkg::CHAR_W-1:0]  mem_wr_data, mem_rd_data;

	// the sequencer takes a new item only when it has nothing in flight
	assign in_stall  = !seq_idle;
	assign in_accept = in_valid && !in_stall;

	// the result register takes the sequencer's result when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	leb_seq #(
		.LINE_CHARS (LINE_CHARS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_accept),
		.cmd          (cmd),
		.key_code     (key_code),
		.key_released (key_released),
		.idle         (seq_idle),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

	leb_store #(
		.LINE_CHARS (LINE_CHARS)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign text_length      = out_q.text_length;
	assign caret_position   = out_q.caret_position;
	assign insert_on        = out_q.insert_on;
	assign char_under_caret = out_q.char_under_caret;
	assign dropped_full     = out_q.dropped_full;

endmodule

@@ rtl/leb_checker.sv @@
// port-level assertions for the line edit buffer and their bind
module leb_checker #(
	parameter int LINE_CHARS = leb_pkg::LINE_CHARS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [leb_pkg::LEN_W-1:0]  text_length,
	input logic [leb_pkg::LEN_W-1:0]  caret_position,
	input logic                       insert_on,
	input logic [leb_pkg::CHAR_W-1:0] char_under_caret,
	input logic                       dropped_full
);

	// caret never passes the end of the text (holds while lengths fit the port)
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (LINE_CHARS < 512) |-> caret_position <= text_length)
	else $error("caret beyond end of text");

	// a dropped character means the line was full
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_full |-> text_length == leb_pkg::LEN_W'(LINE_CHARS))
	else $error("character dropped while line not full");

	// at the end the caret shows no char, inside the text a printable one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (LINE_CHARS < 512) |->
		((caret_position == text_length) && (char_under_caret == '0)) ||
		((caret_position != text_length) && (char_under_caret >= 7'd32) &&
		 (char_under_caret <= 7'd126)))
	else $error("char under caret inconsistent with caret position");

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(text_length) &&
		$stable(caret_position) && $stable(insert_on) &&
		$stable(char_under_caret) && $stable(dropped_full))
	else $error("stalled result item changed");

endmodule

bind line_edit_buffer leb_checker #(
	.LINE_CHARS (LINE_CHARS)
) u_leb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.text_length      (text_length),
	.caret_position   (caret_position),
	.insert_on        (insert_on),
	.char_under_caret (char_under_caret),
	.dropped_full     (dropped_full)
);
